// ===== sv/bppr_pkg.sv =====
// Package for the biosignal packet row parser: parser phase and sequencer
// state types, event and row type codes, and the code-to-type lookups.
// No dependencies.
package bppr_pkg;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CSUM    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_RD_CODE = 2'd1,
    ST_RD_ARG  = 2'd2,
    ST_DECODE  = 2'd3
  } seq_state_t;

  typedef logic [2:0] event_t;
  typedef logic [3:0] row_type_t;

  localparam event_t EV_BYTE     = 3'd0;
  localparam event_t EV_GOOD     = 3'd1;
  localparam event_t EV_LEN_ERR  = 3'd2;
  localparam event_t EV_CSUM_ERR = 3'd3;
  localparam event_t EV_ROW      = 3'd4;
  localparam event_t EV_NO_ROW   = 3'd5;

  localparam row_type_t TY_QUALITY    = 4'd0;
  localparam row_type_t TY_HEART      = 4'd1;
  localparam row_type_t TY_ATTENTION  = 4'd2;
  localparam row_type_t TY_MEDITATION = 4'd3;
  localparam row_type_t TY_RAW8       = 4'd4;
  localparam row_type_t TY_MARKER     = 4'd5;
  localparam row_type_t TY_RAW_WAVE   = 4'd6;
  localparam row_type_t TY_POWER      = 4'd7;
  localparam row_type_t TY_ASIC_POWER = 4'd8;
  localparam row_type_t TY_RR         = 4'd9;
  localparam row_type_t TY_UNKNOWN    = 4'd10;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;

  // Single-byte codes (below 0x80)
  function automatic row_type_t single_type(input logic [7:0] code);
    row_type_t t;
    case (code)
      8'h02:   t = TY_QUALITY;
      8'h03:   t = TY_HEART;
      8'h04:   t = TY_ATTENTION;
      8'h05:   t = TY_MEDITATION;
      8'h06:   t = TY_RAW8;
      8'h07:   t = TY_MARKER;
      default: t = TY_UNKNOWN;
    endcase
    return t;
  endfunction

  // Multi-byte codes (0x80 and above)
  function automatic row_type_t multi_type(input logic [7:0] code);
    row_type_t t;
    case (code)
      8'h80:   t = TY_RAW_WAVE;
      8'h81:   t = TY_POWER;
      8'h83:   t = TY_ASIC_POWER;
      8'h86:   t = TY_RR;
      default: t = TY_UNKNOWN;
    endcase
    return t;
  endfunction

endpackage

// ===== sv/biosignal_packet_row_parser.sv =====
// Top level of the biosignal packet row parser: byte-serial packet framing
// into a two-bank payload store and a row decoder over the readable bank.
// Depends on bppr_pkg.
//
// A transaction is accepted on a clock edge where start is high and busy is
// low. in_action = 0 hands in one serial byte; in_action = 1 asks for the
// next decoded row of the last good packet. Every transaction gives exactly
// one result, shown for a single cycle with out_valid high; the receiver
// cannot stall, so it must take the result in that cycle. A serial byte
// result appears in the cycle after acceptance and busy stays low, so a new
// byte may be offered every cycle. A row fetch passes through the states
// ST_RD_CODE, ST_RD_ARG and ST_DECODE, with busy high: the code byte and
// the byte after it are read one after the other through the single read
// port of the payload store, whose read data is registered, and then the
// row is decoded. A fetch with nothing left to read answers "no row" in the
// next cycle without raising busy. The payload store holds two banks of
// BANK_DEPTH bytes; incoming packets always fill the bank that is not
// readable, and a good checksum swaps the banks. The store is not cleared
// after reset, so no clearing pass is needed: only bytes written by the
// latest good packet are ever read.
module biosignal_packet_row_parser #(
  parameter int BANK_DEPTH  = 256,
  parameter int MAX_PAYLOAD = 169
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_action,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  output bppr_pkg::event_t      out_event_res,
  output bppr_pkg::row_type_t   out_row_type,
  output logic [7:0]            out_row_code,
  output logic [7:0]            out_row_value
);
  import bppr_pkg::*;

  localparam int STORE_DEPTH = 2 * BANK_DEPTH;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int SW          = $clog2(STORE_DEPTH + 512);

  // Bank/position to store address; the sum stays below twice the depth,
  // so one compare and subtract covers the wrap.
  function automatic logic [AW-1:0] addr_of(input logic bank, input logic [8:0] pos);
    logic [SW-1:0] sum;
    sum = (bank ? SW'(BANK_DEPTH) : SW'(0)) + SW'(pos);
    if (sum >= SW'(STORE_DEPTH)) begin
      sum = sum - SW'(STORE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // Payload store
  logic [7:0]    mem [STORE_DEPTH];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data_r;

  // Control registers
  seq_state_t state_r, state_nxt;
  phase_t     phase_r, phase_nxt;
  logic [7:0] exp_len_r, exp_len_nxt;
  logic [7:0] rcv_cnt_r, rcv_cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       rdy_bank_r, rdy_bank_nxt;
  logic [7:0] rdy_len_r, rdy_len_nxt;
  logic [7:0] rd_ptr_r, rd_ptr_nxt;
  logic [7:0] code_r, code_nxt;

  // Result register
  logic       out_valid_r, out_valid_nxt;
  event_t     ev_r, ev_nxt;
  row_type_t  type_r, type_nxt;
  logic [7:0] rcode_r, rcode_nxt;
  logic [7:0] value_r, value_nxt;

  // Decode helpers
  logic [8:0]  cnt_inc;
  logic [8:0]  arg_pos;
  logic [7:0]  arg;
  logic [9:0]  new_pos;
  row_type_t   dec_type;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_rx_byte;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_SYNC1;
      exp_len_r   <= '0;
      rcv_cnt_r   <= '0;
      sum_r       <= '0;
      rdy_bank_r  <= 1'b0;
      rdy_len_r   <= '0;
      rd_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      exp_len_r   <= exp_len_nxt;
      rcv_cnt_r   <= rcv_cnt_nxt;
      sum_r       <= sum_nxt;
      rdy_bank_r  <= rdy_bank_nxt;
      rdy_len_r   <= rdy_len_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload-only registers, no reset
  always_ff @(posedge clk) begin
    code_r  <= code_nxt;
    ev_r    <= ev_nxt;
    type_r  <= type_nxt;
    rcode_r <= rcode_nxt;
    value_r <= value_nxt;
  end

  assign cnt_inc = {1'b0, rcv_cnt_r} + 9'd1;
  assign arg_pos = {1'b0, rd_ptr_r} + 9'd1;
  // Bytes past the readable length read as zero
  assign arg     = (arg_pos < {1'b0, rdy_len_r}) ? rd_data_r : 8'h00;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    exp_len_nxt   = exp_len_r;
    rcv_cnt_nxt   = rcv_cnt_r;
    sum_nxt       = sum_r;
    rdy_bank_nxt  = rdy_bank_r;
    rdy_len_nxt   = rdy_len_r;
    rd_ptr_nxt    = rd_ptr_r;
    code_nxt      = code_r;
    out_valid_nxt = 1'b0;
    ev_nxt        = EV_BYTE;
    type_nxt      = TY_QUALITY;
    rcode_nxt     = 8'h00;
    value_nxt     = 8'h00;
    wr_en         = 1'b0;
    wr_addr       = addr_of(~rdy_bank_r, {1'b0, rcv_cnt_r});
    rd_en         = 1'b0;
    rd_addr       = addr_of(rdy_bank_r, {1'b0, rd_ptr_r});
    new_pos       = '0;
    dec_type      = TY_UNKNOWN;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          if (!in_action) begin
            // Serial byte into the framer
            case (phase_r)
              PH_SYNC1: begin
                if (in_rx_byte == SYNC_BYTE) begin
                  phase_nxt = PH_SYNC2;
                end
              end
              PH_SYNC2: begin
                phase_nxt = (in_rx_byte == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
              end
              PH_LEN: begin
                if ({1'b0, in_rx_byte} > 9'(MAX_PAYLOAD)) begin
                  ev_nxt      = EV_LEN_ERR;
                  phase_nxt   = PH_SYNC1;
                  exp_len_nxt = '0;
                  rcv_cnt_nxt = '0;
                  sum_nxt     = '0;
                end else begin
                  exp_len_nxt = in_rx_byte;
                  rcv_cnt_nxt = '0;
                  sum_nxt     = '0;
                  phase_nxt   = (in_rx_byte == 8'h00) ? PH_CSUM : PH_PAYLOAD;
                end
              end
              PH_PAYLOAD: begin
                wr_en       = 1'b1;
                sum_nxt     = sum_r + in_rx_byte;
                rcv_cnt_nxt = cnt_inc[7:0];
                if (cnt_inc >= {1'b0, exp_len_r}) begin
                  phase_nxt = PH_CSUM;
                end
              end
              PH_CSUM: begin
                phase_nxt   = PH_SYNC1;
                exp_len_nxt = '0;
                rcv_cnt_nxt = '0;
                sum_nxt     = '0;
                if (in_rx_byte != ~sum_r) begin
                  ev_nxt = EV_CSUM_ERR;
                end else begin
                  ev_nxt       = EV_GOOD;
                  rdy_bank_nxt = ~rdy_bank_r;
                  rdy_len_nxt  = exp_len_r;
                  rd_ptr_nxt   = '0;
                end
              end
              default: begin
                phase_nxt   = PH_SYNC1;
                exp_len_nxt = '0;
                rcv_cnt_nxt = '0;
                sum_nxt     = '0;
              end
            endcase
          end else if (rd_ptr_r >= rdy_len_r) begin
            ev_nxt = EV_NO_ROW;
          end else begin
            // Row fetch: read the code byte first
            out_valid_nxt = 1'b0;
            rd_en         = 1'b1;
            state_nxt     = ST_RD_CODE;
          end
        end
      end
      ST_RD_CODE: begin
        // Code byte is on the read port now; the next read overwrites it
        code_nxt  = rd_data_r;
        rd_en     = 1'b1;
        rd_addr   = addr_of(rdy_bank_r, arg_pos);
        state_nxt = ST_RD_ARG;
      end
      ST_RD_ARG: begin
        state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (!code_r[7]) begin
          dec_type  = single_type(code_r);
          value_nxt = (dec_type != TY_UNKNOWN) ? arg : 8'h00;
          new_pos   = {2'b00, rd_ptr_r} + 10'd2;
        end else begin
          dec_type  = multi_type(code_r);
          new_pos   = {2'b00, rd_ptr_r} + 10'd2 + {2'b00, arg};
        end
        rd_ptr_nxt    = (new_pos > {2'b00, rdy_len_r}) ? rdy_len_r : new_pos[7:0];
        type_nxt      = dec_type;
        rcode_nxt     = code_r;
        ev_nxt        = EV_ROW;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_event_res = ev_r;
  assign out_row_type  = type_r;
  assign out_row_code  = rcode_r;
  assign out_row_value = value_r;

endmodule

// ===== sv/bppr_checker.sv =====
// Port-level checker for the biosignal packet row parser, with its bind.
// Depends on bppr_pkg and biosignal_packet_row_parser.
module bppr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                in_action,
  input logic                out_valid,
  input bppr_pkg::event_t    out_event_res,
  input bppr_pkg::row_type_t out_row_type,
  input logic [7:0]          out_row_code,
  input logic [7:0]          out_row_value
);
  import bppr_pkg::*;

  // A serial byte answers in the next cycle with a framing event
  a_byte_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_action |=> out_valid && !busy &&
      (out_event_res == EV_BYTE || out_event_res == EV_GOOD ||
       out_event_res == EV_LEN_ERR || out_event_res == EV_CSUM_ERR))
    else $error("serial byte transaction did not answer next cycle");

  // A fetch answers "no row" at once or goes busy with no result yet
  a_fetch_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_action |=>
      (out_valid && !busy && out_event_res == EV_NO_ROW) || (busy && !out_valid))
    else $error("row fetch started wrongly");

  // Non-row results carry zero row fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != EV_ROW |->
      out_row_type == TY_QUALITY && out_row_code == 8'h00 && out_row_value == 8'h00)
    else $error("row fields not zero on non-row result");

  // Multi-byte and unknown rows carry value zero
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_ROW &&
      (out_row_code[7] || out_row_type == TY_UNKNOWN) |-> out_row_value == 8'h00)
    else $error("nonzero value on multi-byte or unknown row");

  // A row result ends the busy period
  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_ROW |-> $past(busy) && !busy)
    else $error("row result outside fetch sequence");

endmodule

bind biosignal_packet_row_parser bppr_checker u_bppr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_action     (in_action),
  .out_valid     (out_valid),
  .out_event_res (out_event_res),
  .out_row_type  (out_row_type),
  .out_row_code  (out_row_code),
  .out_row_value (out_row_value)
);
